// File: hdl/hsbrgb_pkg.sv
// constants and types for the hsb to rgb duty converter
// used by hsb_to_rgb_duty; depends on nothing
`default_nettype none

package hsbrgb_pkg;

    localparam logic [8:0] HUE_MAX     = 9'd360;
    localparam logic [6:0] PCT_MAX     = 7'd100;
    localparam logic [6:0] SECTOR_SPAN = 7'd120;
    localparam logic [8:0] SECTOR1_LO  = 9'd120;
    localparam logic [8:0] SECTOR2_LO  = 9'd240;

    // duty = bri * num * 256 / 12000 = (bri * num * 8) / 375
    localparam int unsigned DUTY_DIV   = 375;
    localparam int unsigned RECIP_SH   = 32;
    // floor(2^32 / 375)
    localparam logic [23:0] DUTY_RECIP = 24'd11453246;

    typedef logic [1:0]  t_sector;
    typedef logic [13:0] t_weight;
    typedef logic [23:0] t_scaled;
    typedef logic [14:0] t_duty;

    localparam t_sector SECTOR_RG = 2'd0;
    localparam t_sector SECTOR_GB = 2'd1;
    localparam t_sector SECTOR_BR = 2'd2;

endpackage

`default_nettype wire

// File: hdl/hsb_to_rgb_duty.sv
// hsb to rgb pwm duty converter, five-stage pipeline
// depends on hsbrgb_pkg for constants and types
`default_nettype none

// Usage:
//   s_axis carries one color request per beat: hue in degrees, saturation and
//   brightness in percent. m_axis returns red, green and blue pwm duty in
//   units of 1/256 percent, truncated, one result for every request.
//   Out-of-range hue clamps to 360, out-of-range percents clamp to 100.
// Throughput: one request per clock unless stalled; each stage is a register,
//   so a new request enters each such cycle while earlier ones are in flight.
// Pipeline: five register stages (clamp/sector, weights, brightness scale,
//   reciprocal multiply, remainder correction); a result is valid on m_axis
//   when its remainder correction is registered. The divide by 375 is a
//   24x24 reciprocal multiply followed by a single compare and subtract.
// Reset: i_rst_n low clears every valid bit; the pipeline comes up empty.
// Stall: while m_axis_tready is low and a result is waiting, the whole
//   pipeline holds and s_axis_tready drops; nothing is lost or repeated.
//   A waiting result stalls the input even when bubbles remain upstream.
module hsb_to_rgb_duty (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [8:0] hue_deg, [15:9] saturation_pct, [22:16] brightness_pct, [23] zero
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [14:0] red_duty, [29:15] green_duty, [44:30] blue_duty, [47:45] zero
    output logic      [47:0] m_axis_tdata
);

    localparam int NCH = 3;

    logic en;
    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5;

    assign en            = !r_vld5 || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: clamp and pick sector
    logic [8:0] in_hue, hue_c, n_t9;
    logic [6:0] in_sat, in_bri, sat_c, bri_c;
    hsbrgb_pkg::t_sector n_sector;

    logic [6:0]          r1_t, r1_ns, r1_bri;
    hsbrgb_pkg::t_sector r1_sector;

    assign in_hue = s_axis_tdata[8:0];
    assign in_sat = s_axis_tdata[15:9];
    assign in_bri = s_axis_tdata[22:16];

    always_comb begin
        hue_c = (in_hue > hsbrgb_pkg::HUE_MAX) ? hsbrgb_pkg::HUE_MAX : in_hue;
        sat_c = (in_sat > hsbrgb_pkg::PCT_MAX) ? hsbrgb_pkg::PCT_MAX : in_sat;
        bri_c = (in_bri > hsbrgb_pkg::PCT_MAX) ? hsbrgb_pkg::PCT_MAX : in_bri;
        priority if (hue_c < hsbrgb_pkg::SECTOR1_LO) begin
            n_sector = hsbrgb_pkg::SECTOR_RG;
            n_t9     = hue_c;
        end else if (hue_c < hsbrgb_pkg::SECTOR2_LO) begin
            n_sector = hsbrgb_pkg::SECTOR_GB;
            n_t9     = hue_c - hsbrgb_pkg::SECTOR1_LO;
        end else begin
            n_sector = hsbrgb_pkg::SECTOR_BR;
            n_t9     = hue_c - hsbrgb_pkg::SECTOR2_LO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_t      <= n_t9[6:0];
            r1_ns     <= hsbrgb_pkg::PCT_MAX - sat_c;
            r1_bri    <= bri_c;
            r1_sector <= n_sector;
        end
    end

    // stage 2: weights, rotated onto channels
    hsbrgb_pkg::t_weight n_p, n_q, n_w;
    hsbrgb_pkg::t_weight n_num [NCH];
    hsbrgb_pkg::t_weight r2_num [NCH];
    logic [6:0]          r2_bri;

    always_comb begin
        n_p = 14'(hsbrgb_pkg::SECTOR_SPAN - r1_t) * 14'(hsbrgb_pkg::PCT_MAX)
            + 14'(r1_t) * 14'(r1_ns);
        n_q = 14'(r1_t) * 14'(hsbrgb_pkg::PCT_MAX)
            + 14'(hsbrgb_pkg::SECTOR_SPAN - r1_t) * 14'(r1_ns);
        n_w = 14'(hsbrgb_pkg::SECTOR_SPAN) * 14'(r1_ns);
        unique case (r1_sector)
            hsbrgb_pkg::SECTOR_RG: begin
                n_num[0] = n_p; n_num[1] = n_q; n_num[2] = n_w;
            end
            hsbrgb_pkg::SECTOR_GB: begin
                n_num[0] = n_w; n_num[1] = n_p; n_num[2] = n_q;
            end
            default: begin
                n_num[0] = n_q; n_num[1] = n_w; n_num[2] = n_p;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_num <= n_num;
            r2_bri <= r1_bri;
        end
    end

    // stages 3 to 5 per channel: scale, reciprocal multiply, correct
    hsbrgb_pkg::t_scaled r3_z [NCH];
    hsbrgb_pkg::t_scaled r4_z [NCH];
    hsbrgb_pkg::t_duty   r4_q [NCH];
    hsbrgb_pkg::t_duty   r5_duty [NCH];
    hsbrgb_pkg::t_scaled rem [NCH];

    for (genvar c = 0; c < NCH; c++) begin : g_ch
        logic [47:0]         prod;
        hsbrgb_pkg::t_duty   n_duty;

        assign prod = 48'(r3_z[c]) * 48'(hsbrgb_pkg::DUTY_RECIP);
        // estimate is exact or one low
        assign rem[c] = r4_z[c] - 24'(r4_q[c]) * 24'(hsbrgb_pkg::DUTY_DIV);
        assign n_duty = (rem[c] >= 24'(hsbrgb_pkg::DUTY_DIV)) ? r4_q[c] + 15'd1 : r4_q[c];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r3_z[c]    <= 24'(r2_bri) * 24'(r2_num[c]) * 24'd8;
                r4_z[c]    <= r3_z[c];
                r4_q[c]    <= prod[hsbrgb_pkg::RECIP_SH +: 15];
                r5_duty[c] <= n_duty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else if (en) begin
            r_vld1 <= s_axis_tvalid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
        end
    end

    assign m_axis_tvalid = r_vld5;
    assign m_axis_tdata  = {3'b000, r5_duty[2], r5_duty[1], r5_duty[0]};

    // the reciprocal estimate is never more than one low
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld4 |-> (rem[0] < 24'd750 && rem[1] < 24'd750 && rem[2] < 24'd750))
        else $error("duty remainder out of range");

    // duties never exceed full scale
    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[14:0] <= 15'd25600
            && m_axis_tdata[29:15] <= 15'd25600 && m_axis_tdata[44:30] <= 15'd25600))
        else $error("duty above full scale");

    // input side only backs up when a result is waiting downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without an output stall");

    // pipeline comes up empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
